// ----- hw/rtl/rgb_to_hsv_converter_defines.svh -----
// assertion macros for the rgb to hsv converter
// no dependencies; included by rgb_to_hsv_converter.sv, which checks its own logic
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define RHC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rhc assertion failed");
`define RHC_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("rhc forbidden condition seen");
`else
`define RHC_ASSERT(lbl, clk, rstn, prop)
`define RHC_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- hw/rtl/rhc_pkg.sv -----
// shared constants, width helpers and pipeline flag type of the rgb to hsv converter
// no dependencies
`default_nettype none

package rhc_pkg;

    localparam int CHANNEL_BITS_DEF      = 8;
    localparam int HUE_FRACTION_BITS_DEF = 6;
    // 360 degrees needs nine integer bits
    localparam int HUE_INT_BITS          = 9;

    typedef struct packed {
        logic grey;   // max equals min, hue forced to zero
        logic black;  // max is zero, saturation forced to zero
    } pipe_flags_t;

    function automatic int hue_width(input int hf);
        return hf + HUE_INT_BITS;
    endfunction

    // one quotient bit per divider stage, enough for either quotient
    function automatic int div_steps(input int cb, input int hf);
        return (hue_width(hf) > cb) ? hue_width(hf) : cb;
    endfunction

    function automatic int hue_num_width(input int cb, input int hf);
        return cb + hf + 11;
    endfunction

    function automatic int sat_num_width(input int cb);
        return 2 * cb + 2;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rhc_front.sv -----
// front end: dominant channel, min, delta and divider operands over three stages
// depends on rhc_pkg
`default_nettype none

module rhc_front
    import rhc_pkg::*;
#(
    parameter int CB = CHANNEL_BITS_DEF,
    parameter int HF = HUE_FRACTION_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [CB-1:0]                     in_red,
    input  wire logic [CB-1:0]                     in_green,
    input  wire logic [CB-1:0]                     in_blue,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [hue_num_width(CB, HF)-1:0]       out_hue_num,
    output logic [CB:0]                            out_hue_den,
    output logic [sat_num_width(CB)-1:0]           out_sat_num,
    output logic [CB:0]                            out_sat_den,
    output logic [CB-1:0]                          out_value,
    output pipe_flags_t                            out_flags
);

    localparam int KW  = CB + 3;
    localparam int NHW = hue_num_width(CB, HF);
    localparam int NSW = sat_num_width(CB);

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    logic rdy1, rdy2, rdy3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1
    logic [CB-1:0]    mx1_reg, mx1_next, mn1_reg, mn1_next;
    sector_t          sector1_reg, sector1_next;
    logic signed [CB:0] num1_reg, num1_next;

    // stage 2
    logic [CB-1:0]    d2_reg, d2_next, mx2_reg;
    logic [KW-1:0]    m2_reg, m2_next;
    logic [KW-1:0]    kd;
    logic signed [KW:0] m_wide;

    // stage 3
    logic [NHW-1:0]   hue_num_reg, hue_num_next;
    logic [CB:0]      hue_den_reg, hue_den_next, sat_den_reg, sat_den_next;
    logic [NSW-1:0]   sat_num_reg, sat_num_next;
    logic [CB-1:0]    value_reg;
    pipe_flags_t      flags_reg, flags_next;
    logic [CB+6:0]    m15;
    logic [2*CB-1:0]  fsd;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // ties: blue over green over red
    always_comb begin
        mx1_next     = in_red;
        sector1_next = SECT_RED;
        num1_next    = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
        if (in_green >= in_red && in_green >= in_blue) begin
            mx1_next     = in_green;
            sector1_next = SECT_GREEN;
            num1_next    = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
        end
        if (in_blue >= in_green && in_blue >= in_red) begin
            mx1_next     = in_blue;
            sector1_next = SECT_BLUE;
            num1_next    = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
        end
        mn1_next = in_red;
        if (in_green < mn1_next) begin
            mn1_next = in_green;
        end
        if (in_blue < mn1_next) begin
            mn1_next = in_blue;
        end
    end

    // sector offset in units of delta; red with negative distance wraps by six
    always_comb begin
        d2_next = mx1_reg - mn1_reg;
        case (sector1_reg)
            SECT_RED: begin
                kd = num1_reg[CB] ? ((KW'(d2_next) << 2) + (KW'(d2_next) << 1)) : '0;
            end
            SECT_GREEN: begin
                kd = KW'(d2_next) << 1;
            end
            SECT_BLUE: begin
                kd = KW'(d2_next) << 2;
            end
            default: begin
                kd = '0;
            end
        endcase
        m_wide  = $signed({1'b0, kd}) + (KW+1)'(num1_reg);
        m2_next = m_wide[KW-1:0];
    end

    // hue = (120 * 2^hf * m + d) / 2d, sat = (2 * fs * d + max) / 2max
    always_comb begin
        m15            = {m2_reg, 4'b0000} - {4'b0000, m2_reg};
        hue_num_next   = (NHW'(m15) << (HF + 3)) + NHW'(d2_reg);
        hue_den_next   = {d2_reg, 1'b0};
        fsd            = {d2_reg, {CB{1'b0}}} - (2*CB)'(d2_reg);
        sat_num_next   = (NSW'(fsd) << 1) + NSW'(mx2_reg);
        sat_den_next   = {mx2_reg, 1'b0};
        flags_next.grey  = (d2_reg == '0);
        flags_next.black = (mx2_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            mx1_reg     <= mx1_next;
            mn1_reg     <= mn1_next;
            sector1_reg <= sector1_next;
            num1_reg    <= num1_next;
        end
        if (rdy2 && v1_reg) begin
            d2_reg  <= d2_next;
            m2_reg  <= m2_next;
            mx2_reg <= mx1_reg;
        end
        if (rdy3 && v2_reg) begin
            hue_num_reg <= hue_num_next;
            hue_den_reg <= hue_den_next;
            sat_num_reg <= sat_num_next;
            sat_den_reg <= sat_den_next;
            value_reg   <= mx2_reg;
            flags_reg   <= flags_next;
        end
    end

    assign out_valid   = v3_reg;
    assign out_hue_num = hue_num_reg;
    assign out_hue_den = hue_den_reg;
    assign out_sat_num = sat_num_reg;
    assign out_sat_den = sat_den_reg;
    assign out_value   = value_reg;
    assign out_flags   = flags_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rhc_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, hue and saturation side by side
// depends on rhc_pkg
`default_nettype none

module rhc_divider
    import rhc_pkg::*;
#(
    parameter int CB = CHANNEL_BITS_DEF,
    parameter int HF = HUE_FRACTION_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [hue_num_width(CB, HF)-1:0]  in_hue_num,
    input  wire logic [CB:0]                       in_hue_den,
    input  wire logic [sat_num_width(CB)-1:0]      in_sat_num,
    input  wire logic [CB:0]                       in_sat_den,
    input  wire logic [CB-1:0]                     in_value,
    input  wire pipe_flags_t                       in_flags,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [hue_width(HF)-1:0]               out_hue_quo,
    output logic [CB-1:0]                          out_sat_quo,
    output logic [CB-1:0]                          out_value,
    output pipe_flags_t                            out_flags
);

    localparam int S   = div_steps(CB, HF);
    localparam int HB  = hue_width(HF);
    localparam int NHW = hue_num_width(CB, HF);
    localparam int NSW = sat_num_width(CB);
    localparam int CW  = (NHW > NSW) ? NHW : NSW;

    logic [S-1:0]  stage_ready;
    logic          valid_reg   [S];
    logic [CW-1:0] rem_h_reg   [S];
    logic [CW-1:0] rem_s_reg   [S];
    logic [CB:0]   den_h_reg   [S];
    logic [CB:0]   den_s_reg   [S];
    logic [S-1:0]  quo_h_reg   [S];
    logic [S-1:0]  quo_s_reg   [S];
    logic [CB-1:0] value_reg   [S];
    pipe_flags_t   flags_reg   [S];

    for (genvar i = 0; i < S; i++) begin : g_stage
        localparam int J = S - 1 - i;

        logic          p_valid;
        logic [CW-1:0] p_rem_h, p_rem_s;
        logic [CB:0]   p_den_h, p_den_s;
        logic [S-1:0]  p_quo_h, p_quo_s;
        logic [CB-1:0] p_value;
        pipe_flags_t   p_flags;
        logic [CW-1:0] sub_h, sub_s;
        logic          bit_h, bit_s;
        logic [CW-1:0] rem_h_next, rem_s_next;
        logic [S-1:0]  quo_h_next, quo_s_next;

        if (i == 0) begin : g_first
            assign p_valid = in_valid;
            assign p_rem_h = CW'(in_hue_num);
            assign p_rem_s = CW'(in_sat_num);
            assign p_den_h = in_hue_den;
            assign p_den_s = in_sat_den;
            assign p_quo_h = '0;
            assign p_quo_s = '0;
            assign p_value = in_value;
            assign p_flags = in_flags;
        end else begin : g_chain
            assign p_valid = valid_reg[i-1];
            assign p_rem_h = rem_h_reg[i-1];
            assign p_rem_s = rem_s_reg[i-1];
            assign p_den_h = den_h_reg[i-1];
            assign p_den_s = den_s_reg[i-1];
            assign p_quo_h = quo_h_reg[i-1];
            assign p_quo_s = quo_s_reg[i-1];
            assign p_value = value_reg[i-1];
            assign p_flags = flags_reg[i-1];
        end

        if (i == S - 1) begin : g_last_rdy
            assign stage_ready[i] = !valid_reg[i] || out_ready;
        end else begin : g_mid_rdy
            assign stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end

        // try the divisor shifted to this quotient bit
        always_comb begin
            sub_h      = CW'(p_den_h) << J;
            sub_s      = CW'(p_den_s) << J;
            bit_h      = (p_rem_h >= sub_h);
            bit_s      = (p_rem_s >= sub_s);
            rem_h_next = bit_h ? (p_rem_h - sub_h) : p_rem_h;
            rem_s_next = bit_s ? (p_rem_s - sub_s) : p_rem_s;
            quo_h_next = (p_quo_h << 1) | S'(bit_h);
            quo_s_next = (p_quo_s << 1) | S'(bit_s);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (stage_ready[i]) begin
                valid_reg[i] <= p_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[i] && p_valid) begin
                rem_h_reg[i] <= rem_h_next;
                rem_s_reg[i] <= rem_s_next;
                den_h_reg[i] <= p_den_h;
                den_s_reg[i] <= p_den_s;
                quo_h_reg[i] <= quo_h_next;
                quo_s_reg[i] <= quo_s_next;
                value_reg[i] <= p_value;
                flags_reg[i] <= p_flags;
            end
        end
    end

    assign in_ready    = stage_ready[0];
    assign out_valid   = valid_reg[S-1];
    assign out_hue_quo = quo_h_reg[S-1][HB-1:0];
    assign out_sat_quo = quo_s_reg[S-1][CB-1:0];
    assign out_value   = value_reg[S-1];
    assign out_flags   = flags_reg[S-1];

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
// Pipelined RGB to HSV converter. One pixel is taken per clock unless a stalled
// output has filled the pipeline. Three front stages find max, min and the
// divider operands, the restoring divider spends one stage per quotient bit,
// S = max(HUE_FRACTION_BITS + 9, CHANNEL_BITS) stages in all, and one output
// register fixes up grey and black pixels and the 360 degree wrap.
// A stalled output only stops the stages behind it that are full; bubbles close
// up, and s_ready follows m_ready through the stage ready chain in the same cycle.
// Hue is in degrees times 2^HUE_FRACTION_BITS, 0 for grey pixels.
// depends on rhc_pkg, rhc_front, rhc_divider and rgb_to_hsv_converter_defines.svh
`default_nettype none
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS      = CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [CHANNEL_BITS-1:0]                s_red_in,
    input  wire logic [CHANNEL_BITS-1:0]                s_green_in,
    input  wire logic [CHANNEL_BITS-1:0]                s_blue_in,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [hue_width(HUE_FRACTION_BITS)-1:0]     m_hue_out,
    output logic [CHANNEL_BITS-1:0]                     m_saturation_out,
    output logic [CHANNEL_BITS-1:0]                     m_value_out
);

    localparam int CB           = CHANNEL_BITS;
    localparam int HB           = hue_width(HUE_FRACTION_BITS);
    localparam int NHW          = hue_num_width(CB, HUE_FRACTION_BITS);
    localparam int NSW          = sat_num_width(CB);
    localparam int HUE_FULL_INT = 360 * (2 ** HUE_FRACTION_BITS);
    localparam logic [HB-1:0] HUE_FULL = HB'(HUE_FULL_INT);

    logic            fe_valid, fe_ready;
    logic [NHW-1:0]  fe_hue_num;
    logic [CB:0]     fe_hue_den, fe_sat_den;
    logic [NSW-1:0]  fe_sat_num;
    logic [CB-1:0]   fe_value;
    pipe_flags_t     fe_flags;

    logic            dv_valid, dv_ready;
    logic [HB-1:0]   dv_hue_quo;
    logic [CB-1:0]   dv_sat_quo, dv_value;
    pipe_flags_t     dv_flags;

    logic            m_valid_reg;
    logic [HB-1:0]   hue_reg, hue_next;
    logic [CB-1:0]   sat_reg, sat_next, value_reg;

    rhc_front #(
        .CB (CB),
        .HF (HUE_FRACTION_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_red      (s_red_in),
        .in_green    (s_green_in),
        .in_blue     (s_blue_in),
        .out_valid   (fe_valid),
        .out_ready   (fe_ready),
        .out_hue_num (fe_hue_num),
        .out_hue_den (fe_hue_den),
        .out_sat_num (fe_sat_num),
        .out_sat_den (fe_sat_den),
        .out_value   (fe_value),
        .out_flags   (fe_flags)
    );

    rhc_divider #(
        .CB (CB),
        .HF (HUE_FRACTION_BITS)
    ) u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (fe_valid),
        .in_ready    (fe_ready),
        .in_hue_num  (fe_hue_num),
        .in_hue_den  (fe_hue_den),
        .in_sat_num  (fe_sat_num),
        .in_sat_den  (fe_sat_den),
        .in_value    (fe_value),
        .in_flags    (fe_flags),
        .out_valid   (dv_valid),
        .out_ready   (dv_ready),
        .out_hue_quo (dv_hue_quo),
        .out_sat_quo (dv_sat_quo),
        .out_value   (dv_value),
        .out_flags   (dv_flags)
    );

    assign dv_ready = !m_valid_reg || m_ready;

    // zero divisors give all-ones quotients, so grey and black are overridden; a hue of 360 or more wraps to zero
    always_comb begin
        hue_next = dv_hue_quo;
        if (dv_flags.grey || dv_hue_quo >= HUE_FULL) begin
            hue_next = '0;
        end
        sat_next = dv_flags.black ? '0 : dv_sat_quo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dv_ready) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (dv_ready && dv_valid) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= dv_value;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_hue_out        = hue_reg;
    assign m_saturation_out = sat_reg;
    assign m_value_out      = value_reg;

    `RHC_ASSERT(a_hue_in_range, aclk, aresetn, m_valid |-> (m_hue_out < HUE_FULL))
    `RHC_ASSERT(a_black_unsaturated, aclk, aresetn,
        (m_valid && m_value_out == '0) |-> (m_saturation_out == '0))
    `RHC_ASSERT(a_hue_needs_chroma, aclk, aresetn,
        (m_valid && m_hue_out != '0) |-> (m_saturation_out != '0))
    `RHC_ASSERT_NEVER(a_ready_when_drained, aclk, aresetn, !m_valid && !s_ready)

endmodule

`default_nettype wire
